[hw/rtl/tbu_pkg.sv]
// ----------------------------------------------------------------------------
// tbu_pkg: shared types and constants of the token bucket unit
// Field widths, divide-by-one-million constants and the control word that
// follows an item down the pipeline.
// ----------------------------------------------------------------------------
package tbu_pkg;

    localparam int WORKERS_DEF = 16;

    localparam int WORKER_W = 8;
    localparam int TIME_W   = 48;
    localparam int TOK_W    = 20;
    localparam int DROP_W   = 32;
    localparam int PROD_W   = 2 * TOK_W;
    localparam int STAGES   = 6;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [TIME_W-1:0] USEC_PER_SEC = 48'd1000000;

    // 1e6 = 2^6 * 15625; quotient estimate from the top product bits
    localparam int              PRE_SHIFT = 6;
    localparam int              RECIP_W   = 21;
    localparam logic [20:0]     RECIP     = 21'd1099511;   // floor(2^34 / 15625)
    localparam logic [13:0]     DIV_ODD   = 14'd15625;
    localparam int              REM_W     = 17;
    localparam logic [16:0]     REM_ONE   = 17'd15625;
    localparam logic [16:0]     REM_TWO   = 17'd31250;
    localparam logic [16:0]     REM_THREE = 17'd46875;

    typedef struct packed {
        logic [WORKER_W-1:0] worker;
        logic                in_rng;
        logic                lim0;
        logic                first;
        logic                refill;
        logic                full;
    } t_ctl;

endpackage

[hw/rtl/tbu_time_stage.sv]
// ----------------------------------------------------------------------------
// tbu_time_stage: per-worker timestamp stage
// Reads the worker's start bit and last refill time, decides whether a refill
// happens, updates the timestamp and forms elapsed * limit.
// ----------------------------------------------------------------------------
module tbu_time_stage #(
    parameter int WORKERS = tbu_pkg::WORKERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_valid,
    input  logic [tbu_pkg::WORKER_W-1:0]   i_worker,
    input  logic [tbu_pkg::TIME_W-1:0]     i_now,
    input  logic [tbu_pkg::TOK_W-1:0]      i_limit,
    output tbu_pkg::t_ctl                  o_ctl,
    output logic [tbu_pkg::PROD_W-1:0]     o_prod
);
    import tbu_pkg::*;

    localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;

    logic [TIME_W-1:0] r_last [WORKERS];
    logic [WORKERS-1:0] r_started;
    t_ctl               r_ctl;
    logic [PROD_W-1:0]  r_prod;

    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  last;
    logic [TIME_W-1:0]  elapsed;
    logic [PROD_W-1:0]  prod;
    logic               wr;
    t_ctl               n_ctl;

    assign idx     = i_worker[IDX_W-1:0];
    assign last    = r_last[idx];
    assign elapsed = i_now - last;
    assign prod    = PROD_W'(elapsed[TOK_W-1:0]) * PROD_W'(i_limit);

    always_comb begin
        n_ctl.worker = i_worker;
        n_ctl.in_rng = ({1'b0, i_worker} < (WORKER_W + 1)'(WORKERS));
        n_ctl.lim0   = (i_limit == '0);
        n_ctl.first  = !r_started[idx];
        n_ctl.full   = (elapsed >= USEC_PER_SEC);
        n_ctl.refill = (i_now > last) && (n_ctl.full || (prod >= PROD_W'(USEC_PER_SEC)));
    end

    assign wr = i_load && i_valid && n_ctl.in_rng && !n_ctl.lim0
                && (n_ctl.first || n_ctl.refill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
        end else if (wr) begin
            r_started[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_last[idx] <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl  <= n_ctl;
            r_prod <= prod;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;

endmodule

[hw/rtl/tbu_refill_div.sv]
// ----------------------------------------------------------------------------
// tbu_refill_div: refill amount, product / 1000000
// Three stages: reciprocal estimate, remainder, final correction.
// ----------------------------------------------------------------------------
module tbu_refill_div (
    input  logic                        i_clk,
    input  logic                        i_load_a,
    input  logic                        i_load_b,
    input  logic                        i_load_c,
    input  tbu_pkg::t_ctl               i_ctl,
    input  logic [tbu_pkg::PROD_W-1:0]  i_prod,
    output tbu_pkg::t_ctl               o_ctl,
    output logic [tbu_pkg::TOK_W-1:0]   o_quot
);
    import tbu_pkg::*;

    localparam int HI_W  = PROD_W - TOK_W;
    localparam int EST_W = HI_W + RECIP_W;

    t_ctl               r_a_ctl;
    t_ctl               r_b_ctl;
    t_ctl               r_c_ctl;
    logic [RECIP_W-1:0] r_a_est;
    logic [REM_W-1:0]   r_a_lo;
    logic [RECIP_W-1:0] r_b_est;
    logic [REM_W-1:0]   r_b_rem;
    logic [TOK_W-1:0]   r_c_quot;

    logic [EST_W-1:0]           est_prod;
    logic [RECIP_W+13:0]        back_prod;
    logic [REM_W-1:0]           rem;
    logic [1:0]                 fix;
    logic [RECIP_W-1:0]         quot;

    assign est_prod  = EST_W'(i_prod[PROD_W-1:TOK_W]) * EST_W'(RECIP);
    assign back_prod = (RECIP_W + 14)'(r_a_est) * (RECIP_W + 14)'(DIV_ODD);
    assign rem       = r_a_lo - back_prod[REM_W-1:0];

    always_comb begin
        fix  = 2'(r_b_rem >= REM_ONE) + 2'(r_b_rem >= REM_TWO) + 2'(r_b_rem >= REM_THREE);
        quot = r_b_est + RECIP_W'(fix);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_a) begin
            r_a_ctl <= i_ctl;
            r_a_est <= est_prod[EST_W-1:TOK_W];
            r_a_lo  <= i_prod[PRE_SHIFT+REM_W-1:PRE_SHIFT];
        end
        if (i_load_b) begin
            r_b_ctl <= r_a_ctl;
            r_b_est <= r_a_est;
            r_b_rem <= rem;
        end
        if (i_load_c) begin
            r_c_ctl  <= r_b_ctl;
            r_c_quot <= quot[TOK_W-1:0];
        end
    end

    assign o_ctl  = r_c_ctl;
    assign o_quot = r_c_quot;

endmodule

[hw/rtl/tbu_token_stage.sv]
// ----------------------------------------------------------------------------
// tbu_token_stage: bucket update and result register
// Read-modify-write of the worker's token count in one stage, drop counter,
// registered result fields.
// ----------------------------------------------------------------------------
module tbu_token_stage #(
    parameter int WORKERS = tbu_pkg::WORKERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_valid,
    input  tbu_pkg::t_ctl               i_ctl,
    input  logic [tbu_pkg::TOK_W-1:0]   i_quot,
    input  logic [tbu_pkg::TOK_W-1:0]   i_limit,
    output logic                        o_allowed,
    output logic [tbu_pkg::TOK_W-1:0]   o_left,
    output logic [tbu_pkg::DROP_W-1:0]  o_drops
);
    import tbu_pkg::*;

    localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;

    logic [TOK_W-1:0]  r_tok [WORKERS];
    logic [DROP_W-1:0] r_drop;
    logic              r_allowed;
    logic [TOK_W-1:0]  r_left;
    logic [DROP_W-1:0] r_drops;

    logic [IDX_W-1:0]  idx;
    logic [TOK_W-1:0]  tok;
    logic [TOK_W:0]    sum;
    logic [TOK_W-1:0]  capped;
    logic [TOK_W-1:0]  base;
    logic [TOK_W-1:0]  n_tok;
    logic [TOK_W-1:0]  n_left;
    logic [DROP_W-1:0] n_drop;
    logic              n_allowed;
    logic              wr;

    assign idx    = i_ctl.worker[IDX_W-1:0];
    assign tok    = r_tok[idx];
    assign sum    = {1'b0, tok} + {1'b0, i_quot};
    assign capped = (i_ctl.full || (sum > {1'b0, i_limit})) ? i_limit : sum[TOK_W-1:0];
    assign base   = i_ctl.refill ? capped : tok;

    always_comb begin
        n_allowed = 1'b1;
        n_left    = '0;
        n_tok     = tok;
        n_drop    = r_drop;
        wr        = 1'b0;
        if (i_ctl.in_rng) begin
            if (i_ctl.lim0) begin
                n_left = i_ctl.first ? '0 : tok;
            end else if (i_ctl.first) begin
                n_tok  = i_limit;
                n_left = i_limit;
                wr     = 1'b1;
            end else begin
                if (base != '0) begin
                    n_tok = base - 1'b1;
                end else begin
                    n_tok     = '0;
                    n_allowed = 1'b0;
                    n_drop    = r_drop + 1'b1;
                end
                n_left = n_tok;
                wr     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= '0;
        end else if (i_load && i_valid) begin
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid && wr) begin
            r_tok[idx] <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_allowed <= n_allowed;
            r_left    <= n_left;
            r_drops   <= n_drop;
        end
    end

    assign o_allowed = r_allowed;
    assign o_left    = r_left;
    assign o_drops   = r_drops;

endmodule

[hw/rtl/per_worker_token_bucket_unit.sv]
// Stages: input register, timestamp, estimate, remainder, correction, tokens.
// Throughput: one item per cycle unless stalled, also when consecutive items name the
// same worker; timestamps and token counts are each read and written in one stage.
// Back-pressure stalls only the stages that are full; bubbles are squeezed out.
// Reset (synchronous): empties the pipeline, clears start bits, drop count and
// the limit register; token and timestamp stores need no clearing pass.
// ----------------------------------------------------------------------------
// per_worker_token_bucket_unit: per-worker token bucket rate limiter
// Stream in requests (worker, time in us), stream out allowed/tokens/drops.
// ----------------------------------------------------------------------------
module per_worker_token_bucket_unit #(
    parameter int WORKERS = tbu_pkg::WORKERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tbu_pkg::TOK_W-1:0]       i_cfg_data,     // tokens_per_second
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tbu_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // worker[7:0], now_us[55:8]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tbu_pkg::M_TDATA_W-1:0]   m_axis_tdata    // allowed[0], tokens_left[20:1],
                                                            // drops_total[52:21]
);
    import tbu_pkg::*;

    logic [TOK_W-1:0]    r_limit;
    logic [STAGES-1:0]   r_vld;
    logic [WORKER_W-1:0] r_worker;
    logic [TIME_W-1:0]   r_now;

    logic [STAGES-1:0]   en;
    logic [STAGES-1:0]   n_vld;
    t_ctl                time_ctl;
    t_ctl                div_ctl;
    logic [PROD_W-1:0]   time_prod;
    logic [TOK_W-1:0]    div_quot;
    logic                out_allowed;
    logic [TOK_W-1:0]    out_left;
    logic [DROP_W-1:0]   out_drops;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld = {r_vld[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_worker <= s_axis_tdata[WORKER_W-1:0];
            r_now    <= s_axis_tdata[WORKER_W+TIME_W-1:WORKER_W];
        end
    end

    tbu_time_stage #(
        .WORKERS (WORKERS)
    ) u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (en[1]),
        .i_valid  (r_vld[0]),
        .i_worker (r_worker),
        .i_now    (r_now),
        .i_limit  (r_limit),
        .o_ctl    (time_ctl),
        .o_prod   (time_prod)
    );

    tbu_refill_div u_div (
        .i_clk    (i_clk),
        .i_load_a (en[2]),
        .i_load_b (en[3]),
        .i_load_c (en[4]),
        .i_ctl    (time_ctl),
        .i_prod   (time_prod),
        .o_ctl    (div_ctl),
        .o_quot   (div_quot)
    );

    tbu_token_stage #(
        .WORKERS (WORKERS)
    ) u_token (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (en[5]),
        .i_valid   (r_vld[4]),
        .i_ctl     (div_ctl),
        .i_quot    (div_quot),
        .i_limit   (r_limit),
        .o_allowed (out_allowed),
        .o_left    (out_left),
        .o_drops   (out_drops)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {(M_TDATA_W - 1 - TOK_W - DROP_W)'(0), out_drops, out_left,
                            out_allowed};

endmodule

[hw/rtl/tbu_checker.sv]
// ----------------------------------------------------------------------------
// tbu_port_checker: port-level checks of the token bucket unit
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
module tbu_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tbu_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import tbu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_drop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[TOK_W:1] == '0)
        else $error("dropped item with tokens left");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind per_worker_token_bucket_unit tbu_port_checker u_tbu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
